// ===== design/isat_pkg.sv =====
// ----------------------------------------------------------------------------
// ID slot allocator table package
// Shared widths, request modes, status codes and register indexes.
// ----------------------------------------------------------------------------
package isat_pkg;

  // Payload widths fixed by the interface.
  localparam int unsigned ID_W       = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BASE_W     = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // The occupancy bitmap holds one bit per slot, packed into rows.
  localparam int unsigned ROW_BITS   = 32;
  localparam int unsigned ROW_IDX_W  = 5;

  // Request modes; codes five to seven are unused.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOCATE = 3'd0,
    MODE_SET      = 3'd1,
    MODE_GET      = 3'd2,
    MODE_RELEASE  = 3'd3,
    MODE_CHECK    = 3'd4
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NONE_FREE = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_BASE  = 1'b0,
    CFG_ID_COUNT = 1'b1
  } cfg_reg_e;

endpackage

// ===== design/isat_ram.sv =====
// ----------------------------------------------------------------------------
// Single-port synchronous RAM
// One access per cycle, read-first, read data registered.
// ----------------------------------------------------------------------------
module isat_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port and registered read port share the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/isat_ctrl.sv =====
// ----------------------------------------------------------------------------
// ID slot allocator controller
// Window registers, request sequencer, bitmap scan and result register.
// ----------------------------------------------------------------------------
module isat_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned AW          = 10,
  parameter int unsigned RAW         = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [isat_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [isat_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [isat_pkg::MODE_W-1:0]       mode_i,
  input  logic [isat_pkg::ID_W-1:0]         id_i,
  input  logic [isat_pkg::VALUE_W-1:0]      write_value_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [isat_pkg::STATUS_W-1:0]     status_o,
  output logic [isat_pkg::VALUE_W-1:0]      data_out_o,
  output logic [isat_pkg::ID_W-1:0]         found_id_o,
  // Value memory
  output logic                              val_we_o,
  output logic [AW-1:0]                     val_addr_o,
  output logic [isat_pkg::VALUE_W-1:0]      val_wdata_o,
  input  logic [isat_pkg::VALUE_W-1:0]      val_rdata_i,
  // Occupancy bitmap memory
  output logic                              occ_we_o,
  output logic [RAW-1:0]                    occ_addr_o,
  output logic [isat_pkg::ROW_BITS-1:0]     occ_wdata_o,
  input  logic [isat_pkg::ROW_BITS-1:0]     occ_rdata_i
);

  localparam int unsigned NROWS = (TABLE_DEPTH + isat_pkg::ROW_BITS - 1) / isat_pkg::ROW_BITS;
  // Wide enough for the ID space, the table depth and a row past the end.
  localparam int unsigned LW = (ID_BITS + 1 > 18) ? ID_BITS + 1 : 18;
  localparam logic [LW-1:0] ID_MASK  = LW'((64'd1 << ID_BITS) - 64'd1);
  localparam logic [LW-1:0] DEPTH_L  = LW'(TABLE_DEPTH);
  localparam logic [LW-1:0] ROW_L    = LW'(isat_pkg::ROW_BITS);
  localparam logic [RAW-1:0] LAST_ROW = RAW'(NROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e                               state_q;
  logic [isat_pkg::BASE_W-1:0]          base_q;
  logic [isat_pkg::COUNT_W-1:0]         count_q;
  logic [LW-1:0]                        n_q, n_d;
  logic [RAW-1:0]                       clr_row_q;
  logic [isat_pkg::MODE_W-1:0]          mode_q;
  logic [isat_pkg::ID_W-1:0]            id_q;
  logic [isat_pkg::VALUE_W-1:0]         wval_q;
  logic [AW-1:0]                        pos_q;
  logic [RAW-1:0]                       row_q;
  logic [isat_pkg::ROW_IDX_W-1:0]       bit_q;
  logic [RAW-1:0]                       scan_row_q;
  logic [RAW-1:0]                       chk_row_q;
  logic                                 chk_vld_q;
  isat_pkg::status_e                    res_status_q;
  logic [isat_pkg::VALUE_W-1:0]         res_data_q;
  logic [isat_pkg::ID_W-1:0]            res_found_q;
  logic                                 out_valid_q;
  isat_pkg::status_e                    out_status_q;
  logic [isat_pkg::VALUE_W-1:0]         out_data_q;
  logic [isat_pkg::ID_W-1:0]            out_found_q;

  logic [LW-1:0]                        base_l, cnt_l, cnt_sat, room;
  logic [LW-1:0]                        id_l, diff;
  logic                                 in_win;
  logic                                 in_acc;
  logic                                 emit;
  logic                                 mode_addr;
  logic [LW-1:0]                        row_start, rem, slot;
  logic [isat_pkg::ROW_BITS-1:0]        row_mask, free_vec, occ_new;
  logic [isat_pkg::ROW_IDX_W-1:0]       enc;
  logic                                 any_free, last_row;

  // Number of usable slots: count clipped to the depth and to the ID space.
  always_comb begin
    base_l  = LW'(base_q);
    cnt_l   = LW'(count_q);
    cnt_sat = (cnt_l > DEPTH_L) ? DEPTH_L : cnt_l;
    room    = (base_l > ID_MASK) ? '0 : (ID_MASK - base_l + LW'(1));
    n_d     = (cnt_sat > room) ? room : cnt_sat;
  end

  // Window lookup for the latched request.
  always_comb begin
    id_l      = LW'(id_q) & ID_MASK;
    diff      = id_l - base_l;
    in_win    = (id_l >= base_l) && (diff < n_q);
    mode_addr = (mode_q == isat_pkg::MODE_SET) || (mode_q == isat_pkg::MODE_GET) ||
                (mode_q == isat_pkg::MODE_RELEASE) || (mode_q == isat_pkg::MODE_CHECK);
  end

  // Free-slot search within the bitmap row that returned this cycle.
  always_comb begin
    row_start = LW'(chk_row_q) << isat_pkg::ROW_IDX_W;
    rem       = (n_q > row_start) ? (n_q - row_start) : '0;
    for (int b = 0; b < isat_pkg::ROW_BITS; b++) begin
      row_mask[b] = (LW'(b) < rem);
    end
    free_vec = ~occ_rdata_i & row_mask;
    any_free = |free_vec;
    enc      = '0;
    for (int b = isat_pkg::ROW_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        enc = isat_pkg::ROW_IDX_W'(b);
      end
    end
    slot     = row_start + LW'(enc);
    last_row = (row_start + ROW_L) >= n_q;
  end

  // Memory addressing and write-back of the occupancy bit.
  always_comb begin
    occ_new          = occ_rdata_i;
    occ_new[bit_q]   = (mode_q == isat_pkg::MODE_SET) && (wval_q != '0);
    val_wdata_o      = wval_q;
    val_we_o         = (state_q == S_RMW) && (mode_q == isat_pkg::MODE_SET);
    val_addr_o       = (state_q == S_DECODE) ? diff[AW-1:0] : pos_q;
    occ_we_o         = 1'b0;
    occ_wdata_o      = occ_new;
    unique case (state_q)
      S_CLEAR: begin
        occ_addr_o  = clr_row_q;
        occ_we_o    = 1'b1;
        occ_wdata_o = '0;
      end
      S_DECODE: occ_addr_o = diff[RAW+isat_pkg::ROW_IDX_W-1:isat_pkg::ROW_IDX_W];
      S_RMW: begin
        occ_addr_o = row_q;
        occ_we_o   = (mode_q == isat_pkg::MODE_SET) || (mode_q == isat_pkg::MODE_RELEASE);
      end
      S_SCAN:  occ_addr_o = scan_row_q;
      default: occ_addr_o = row_q;
    endcase
  end

  // A window write in the same cycle keeps the request channel closed.
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || cfg_we_i;

  // The result register takes a new result once it is empty or being taken.
  assign emit = (state_q == S_EMIT) && !cfg_we_i && (!out_valid_q || !out_stall_i);

  // Sequencer, window registers and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      base_q       <= '0;
      count_q      <= isat_pkg::COUNT_W'(1024);
      n_q          <= '0;
      clr_row_q    <= '0;
      mode_q       <= '0;
      id_q         <= '0;
      wval_q       <= '0;
      pos_q        <= '0;
      row_q        <= '0;
      bit_q        <= '0;
      scan_row_q   <= '0;
      chk_row_q    <= '0;
      chk_vld_q    <= 1'b0;
      res_status_q <= isat_pkg::ST_OK;
      res_data_q   <= '0;
      res_found_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= isat_pkg::ST_OK;
      out_data_q   <= '0;
      out_found_q  <= '0;
    end else begin
      n_q <= n_d;
      // The result register fills on a new result and empties when taken.
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        // A window write restarts the bitmap clearing pass.
        unique case (isat_pkg::cfg_reg_e'(cfg_idx_i))
          isat_pkg::CFG_ID_BASE:  base_q  <= cfg_wdata_i[isat_pkg::BASE_W-1:0];
          isat_pkg::CFG_ID_COUNT: count_q <= cfg_wdata_i[isat_pkg::COUNT_W-1:0];
          default: ;
        endcase
        state_q   <= S_CLEAR;
        clr_row_q <= '0;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_row_q <= clr_row_q + RAW'(1);
            if (clr_row_q == LAST_ROW) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              mode_q  <= mode_i;
              id_q    <= id_i;
              wval_q  <= write_value_i;
              state_q <= S_DECODE;
            end
          end
          S_DECODE: begin
            pos_q        <= diff[AW-1:0];
            row_q        <= diff[RAW+isat_pkg::ROW_IDX_W-1:isat_pkg::ROW_IDX_W];
            bit_q        <= diff[isat_pkg::ROW_IDX_W-1:0];
            res_status_q <= isat_pkg::ST_OK;
            res_data_q   <= '0;
            res_found_q  <= '0;
            if (mode_q == isat_pkg::MODE_ALLOCATE) begin
              scan_row_q <= '0;
              chk_vld_q  <= 1'b0;
              state_q    <= S_SCAN;
            end else if (mode_addr && !in_win) begin
              res_status_q <= isat_pkg::ST_RANGE;
              state_q      <= S_EMIT;
            end else if (mode_addr && (mode_q != isat_pkg::MODE_CHECK)) begin
              state_q <= S_RMW;
            end else begin
              state_q <= S_EMIT;
            end
          end
          S_RMW: begin
            // A clear occupancy bit means the stored value is zero.
            res_data_q <= occ_rdata_i[bit_q] ? val_rdata_i : '0;
            state_q    <= S_EMIT;
          end
          S_SCAN: begin
            scan_row_q <= scan_row_q + RAW'(1);
            chk_row_q  <= scan_row_q;
            chk_vld_q  <= 1'b1;
            if (chk_vld_q) begin
              if (any_free) begin
                res_status_q <= isat_pkg::ST_OK;
                res_found_q  <= isat_pkg::ID_W'(base_l + slot);
                state_q      <= S_EMIT;
              end else if (last_row) begin
                res_status_q <= isat_pkg::ST_NONE_FREE;
                state_q      <= S_EMIT;
              end
            end
          end
          S_EMIT: begin
            if (emit) begin
              out_status_q <= res_status_q;
              out_data_q   <= res_data_q;
              out_found_q  <= res_found_q;
              state_q      <= S_IDLE;
            end
          end
          default: state_q <= S_CLEAR;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign found_id_o  = out_found_q;

  // A window write always blocks requests while the bitmap is cleared.
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("request channel open right after a window write");

  // One request at a time: an accepted transaction closes the channel.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request channel open while a transaction is in work");

  // Only an allocation can end with no free ID.
  a_none_free_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_status_q == isat_pkg::ST_NONE_FREE) |->
    mode_q == isat_pkg::MODE_ALLOCATE)
    else $error("no-free status for a request that is not an allocation");

  // An allocation never ends with the out-of-window status.
  a_range_not_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_status_q == isat_pkg::ST_RANGE) |->
    mode_q != isat_pkg::MODE_ALLOCATE)
    else $error("out-of-window status for an allocation");

endmodule

// ===== design/id_slot_allocator_table.sv =====
// ----------------------------------------------------------------------------
// ID slot allocator table
// One 32-bit value per ID of a configured window, with lowest-free search.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. Set, get and release requests pass
// through a read of the value memory and the occupancy bitmap, a write-back,
// and the result register before the next acceptance. Check, out-of-window
// and unused-mode requests skip the write-back. Allocate scans the occupancy
// bitmap one 32-slot row per cycle from the bottom of the window and stops at
// the first row with a free slot or at the last row of the window; it always
// checks at least one row. After reset and after every write of either window
// register, the bitmap is cleared one row per cycle, and no request is accepted
// meanwhile. A result waits in the output register until taken; the next
// request is accepted meanwhile and holds only in its result state for as
// long as the earlier result is still untaken.
module id_slot_allocator_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [isat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [isat_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [isat_pkg::MODE_W-1:0]     mode_i,
  input  logic [isat_pkg::ID_W-1:0]       id_i,
  input  logic signed [isat_pkg::VALUE_W-1:0] write_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [isat_pkg::STATUS_W-1:0]   status_o,
  output logic signed [isat_pkg::VALUE_W-1:0] data_out_o,
  output logic [isat_pkg::ID_W-1:0]       found_id_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned NROWS = (TABLE_DEPTH + isat_pkg::ROW_BITS - 1) / isat_pkg::ROW_BITS;
  localparam int unsigned RAW   = (NROWS > 1) ? $clog2(NROWS) : 1;

  logic                           val_we;
  logic [AW-1:0]                  val_addr;
  logic [isat_pkg::VALUE_W-1:0]   val_wdata, val_rdata;
  logic                           occ_we;
  logic [RAW-1:0]                 occ_addr;
  logic [isat_pkg::ROW_BITS-1:0]  occ_wdata, occ_rdata;
  logic [isat_pkg::VALUE_W-1:0]   data_out;

  // Request sequencer and window registers.
  isat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .AW          (AW),
    .RAW         (RAW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .id_i          (id_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out),
    .found_id_o    (found_id_o),
    .val_we_o      (val_we),
    .val_addr_o    (val_addr),
    .val_wdata_o   (val_wdata),
    .val_rdata_i   (val_rdata),
    .occ_we_o      (occ_we),
    .occ_addr_o    (occ_addr),
    .occ_wdata_o   (occ_wdata),
    .occ_rdata_i   (occ_rdata)
  );

  assign data_out_o = data_out;

  // Stored values; the controller returns zero for an entry whose occupancy bit is clear.
  isat_ram #(
    .DATA_W (isat_pkg::VALUE_W),
    .ADDR_W (AW)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .addr_i  (val_addr),
    .wdata_i (val_wdata),
    .rdata_o (val_rdata)
  );

  // Occupancy bitmap, one bit per slot, 32 slots per row.
  isat_ram #(
    .DATA_W (isat_pkg::ROW_BITS),
    .ADDR_W (RAW)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .addr_i  (occ_addr),
    .wdata_i (occ_wdata),
    .rdata_o (occ_rdata)
  );

endmodule

// ===== test/tb_id_slot_allocator_table.sv =====
// ----------------------------------------------------------------------------
// ID slot allocator table testbench
// Drives allocate, set, get, release and check requests into the block and
// compares every result with an answer written out in the directed plan or
// with an in-bench prediction of the value table. A directed table covers
// window edges, range errors, an exhausted window and unused modes. Random
// phases then vary the window, idling and backpressure.
module tb_id_slot_allocator_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH     = 1024;
  localparam int unsigned ID_BITS         = 16;
  localparam int unsigned ID_SPACE        = 1 << ID_BITS;
  localparam int unsigned DIRECTED_ROWS   = 29;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned LIMIT_CYCLES    = 400000;

  // Mode codes that the block does not use.
  localparam logic [isat_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [isat_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct {
    logic [isat_pkg::MODE_W-1:0]         mode;
    logic [isat_pkg::ID_W-1:0]           id;
    logic signed [isat_pkg::VALUE_W-1:0] value;
  } req_t;

  typedef struct {
    isat_pkg::status_e                   status;
    logic signed [isat_pkg::VALUE_W-1:0] data;
    logic [isat_pkg::ID_W-1:0]           found;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One row of the directed plan: a request or a register write. Where the
  // answer is obvious it is written out; otherwise the prediction is used.
  typedef struct {
    row_kind_e                   kind;
    isat_pkg::cfg_reg_e          sel;
    logic [isat_pkg::MODE_W-1:0] mode;
    logic [isat_pkg::ID_W-1:0]   id;
    logic [31:0]                 value;
    bit                          known;
    isat_pkg::status_e           st;
    logic [31:0]                 data;
    logic [isat_pkg::ID_W-1:0]   found;
  } plan_row_t;

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 cfg_we_i      = 1'b0;
  logic [isat_pkg::CFG_IDX_W-1:0]       cfg_idx_i     = '0;
  logic [isat_pkg::CFG_DATA_W-1:0]      cfg_wdata_i   = '0;
  logic                                 in_valid_i    = 1'b0;
  logic                                 in_stall_o;
  logic [isat_pkg::MODE_W-1:0]          mode_i        = '0;
  logic [isat_pkg::ID_W-1:0]            id_i          = '0;
  logic signed [isat_pkg::VALUE_W-1:0]  write_value_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i   = 1'b0;
  logic [isat_pkg::STATUS_W-1:0]        status_o;
  logic signed [isat_pkg::VALUE_W-1:0]  data_out_o;
  logic [isat_pkg::ID_W-1:0]            found_id_o;

  // Predicted block state.
  logic [isat_pkg::VALUE_W-1:0] slot_values [TABLE_DEPTH];
  logic [isat_pkg::BASE_W-1:0]  win_base;
  logic [isat_pkg::COUNT_W-1:0] win_count;

  answer_t     pending_answers [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct  = 0;
  bit          hold_go       = 1'b0;
  logic        hold_active   = 1'b0;

  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    // Reset window: base 0, 1024 IDs, all free.
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      1, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd0, 32'h7FFF_FFFF,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      1, isat_pkg::ST_OK, 32'h0, 16'd1},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd1023, 32'h8000_0000,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_GET, 16'd1023, 32'h0,
      1, isat_pkg::ST_OK, 32'h8000_0000, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_GET, 16'd1024, 32'h0,
      1, isat_pkg::ST_RANGE, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'hFFFF, 32'h1,
      1, isat_pkg::ST_RANGE, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_RELEASE, 16'd0, 32'h0,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd1, 32'hFFFF_FFFF,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd1, 32'h0,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_CHECK, 16'd1023, 32'h0,
      1, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_CHECK, 16'd1024, 32'h0,
      1, isat_pkg::ST_RANGE, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, MODE_UNUSED_LO, 16'hFFFF, 32'hFFFF_FFFF,
      1, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, MODE_UNUSED_HI, 16'd3, 32'h5,
      1, isat_pkg::ST_OK, 32'h0, 16'd0},
    // Window at the top of the ID space with an oversized count.
    '{ROW_CFG, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'hFFF0,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_CFG, isat_pkg::CFG_ID_COUNT, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h07FF,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      1, isat_pkg::ST_OK, 32'h0, 16'hFFF0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'hFFFF, 32'h5555_5555,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_GET, 16'hFFFF, 32'h0,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_CHECK, 16'hFFEF, 32'h0,
      1, isat_pkg::ST_RANGE, 32'h0, 16'd0},
    // Two-entry window, filled up; upper data bits of the count are dropped.
    '{ROW_CFG, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'd100,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_CFG, isat_pkg::CFG_ID_COUNT, isat_pkg::MODE_ALLOCATE, 16'd0, 32'hF802,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd100, 32'h1,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd101, 32'h2,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      1, isat_pkg::ST_NONE_FREE, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_SET, 16'd102, 32'h3,
      1, isat_pkg::ST_RANGE, 32'h0, 16'd0},
    // Empty window.
    '{ROW_CFG, isat_pkg::CFG_ID_COUNT, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      0, isat_pkg::ST_OK, 32'h0, 16'd0},
    '{ROW_REQ, isat_pkg::CFG_ID_BASE, isat_pkg::MODE_ALLOCATE, 16'd0, 32'h0,
      1, isat_pkg::ST_NONE_FREE, 32'h0, 16'd0}
  };

  id_slot_allocator_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .id_i         (id_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .found_id_o   (found_id_o)
  );

  always #4 clk_i = ~clk_i;

  // Number of IDs in the window, limited by the table depth and the ID space.
  function automatic int unsigned window_slots();
    int unsigned n;
    int unsigned room;
    n = (win_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(win_count);
    room = ID_SPACE - int'(win_base);
    return (n > room) ? room : n;
  endfunction

  // Lowest free ID of the window, if there is one.
  function automatic bit lowest_free(output logic [isat_pkg::ID_W-1:0] slot_id);
    int unsigned n;
    n = window_slots();
    slot_id = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (slot_values[i] == '0) begin
        slot_id = win_base + isat_pkg::ID_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // A window register write also clears the whole table.
  function automatic void load_window_reg(isat_pkg::cfg_reg_e sel,
                                          logic [isat_pkg::CFG_DATA_W-1:0] data);
    if (sel == isat_pkg::CFG_ID_BASE) begin
      win_base = data[isat_pkg::BASE_W-1:0];
    end else begin
      win_count = data[isat_pkg::COUNT_W-1:0];
    end
    foreach (slot_values[i]) slot_values[i] = '0;
  endfunction

  // Answer of one request; updates the predicted table.
  function automatic answer_t predict_answer(req_t r);
    answer_t                   a;
    int unsigned               pos;
    logic [isat_pkg::ID_W-1:0] slot_id;
    a = '{isat_pkg::ST_OK, '0, '0};
    if (r.mode == isat_pkg::MODE_ALLOCATE) begin
      if (lowest_free(slot_id)) begin
        a.found = slot_id;
      end else begin
        a.status = isat_pkg::ST_NONE_FREE;
      end
    end else if (r.mode == isat_pkg::MODE_SET || r.mode == isat_pkg::MODE_GET ||
                 r.mode == isat_pkg::MODE_RELEASE || r.mode == isat_pkg::MODE_CHECK) begin
      if (r.id < win_base || int'(r.id) - int'(win_base) >= int'(window_slots())) begin
        a.status = isat_pkg::ST_RANGE;
      end else begin
        pos = int'(r.id) - int'(win_base);
        if (r.mode != isat_pkg::MODE_CHECK) begin
          a.data = slot_values[pos];
        end
        if (r.mode == isat_pkg::MODE_SET) begin
          slot_values[pos] = r.value;
        end else if (r.mode == isat_pkg::MODE_RELEASE) begin
          slot_values[pos] = '0;
        end
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one request, with random idle cycles ahead of it, and record the
  // expected answer once the transaction is accepted.
  task automatic send_req(req_t r, bit known, answer_t fixed);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= r.mode;
    id_i          <= r.id;
    write_value_i <= r.value;
    do @(posedge clk_i); while (in_stall_o);
    a = predict_answer(r);
    pending_answers.push_back(known ? fixed : a);
  endtask

  // Write one window register once the block has gone quiet.
  task automatic write_reg(isat_pkg::cfg_reg_e sel, logic [isat_pkg::CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0 || in_stall_o) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_window_reg(sel, data);
    @(posedge clk_i);
  endtask

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk_i) begin : rx_side
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d data %h found %h",
                                  status_o, data_out_o, found_id_o));
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, predicted %0d", status_o, want.status));
        end
        if (data_out_o !== want.data) begin
          report_mismatch($sformatf("data_out %h, predicted %h", data_out_o, want.data));
        end
        if (found_id_o !== want.found) begin
          report_mismatch($sformatf("found_id %h, predicted %h", found_id_o, want.found));
        end
      end
    end
    out_stall_i <= hold_active || ($urandom_range(99) < rx_stall_pct);
  end

  // Long receiver hold-off so that the block fills and stalls its input.
  initial begin : hold_off
    int unsigned hold_count;
    wait (hold_go);
    @(posedge clk_i);
    hold_active <= 1'b1;
    hold_count = 0;
    while (hold_count < HOLD_CYCLES) begin
      @(posedge clk_i);
      hold_count++;
    end
    hold_active <= 1'b0;
  end

  // Cycle limit for a hung run.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus: directed plan, then random phases.
  initial begin : stimulus
    req_t                      r;
    logic [isat_pkg::ID_W-1:0] slot_id;
    int unsigned               sent;
    int unsigned               pick;
    int unsigned               n;
    logic [15:0]               base_w;
    logic [15:0]               count_w;

    load_window_reg(isat_pkg::CFG_ID_BASE, 16'd0);
    load_window_reg(isat_pkg::CFG_ID_COUNT, 16'd1024);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_CFG) begin
        write_reg(directed_plan[k].sel, directed_plan[k].value[isat_pkg::CFG_DATA_W-1:0]);
      end else begin
        r = '{directed_plan[k].mode, directed_plan[k].id, directed_plan[k].value};
        send_req(r, directed_plan[k].known,
                 '{directed_plan[k].st, directed_plan[k].data, directed_plan[k].found});
      end
    end

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      // Window of this phase: full, top-of-space and oversized windows, small ones, and a random one last.
      case (p)
        0: begin base_w = 16'd0;  count_w = 16'd1024; end
        1: begin base_w = 16'hFFFF; count_w = 16'($urandom_range(1, 40)); end
        2: begin base_w = 16'($urandom); count_w = 16'($urandom_range(1, 12)); end
        3: begin base_w = 16'($urandom); count_w = 16'h07FF; end
        4: begin base_w = 16'hFC00 + 16'($urandom_range(0, 1023)); count_w = 16'd1024; end
        5: begin base_w = 16'($urandom); count_w = 16'($urandom_range(1, 64)); end
        6: begin base_w = 16'($urandom); count_w = 16'($urandom_range(0, 3)); end
        default: begin base_w = 16'($urandom); count_w = 16'($urandom); end
      endcase
      write_reg(isat_pkg::CFG_ID_BASE, base_w);
      write_reg(isat_pkg::CFG_ID_COUNT, count_w);

      case (p % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin send_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      if (p == 4) begin
        hold_go = 1'b1;
      end

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        n = window_slots();
        // Mostly IDs inside the window, some just outside or anywhere.
        pick = $urandom_range(99);
        if (n == 0 || pick < 6) begin
          r.id = 16'($urandom);
        end else if (pick < 10) begin
          r.id = (pick < 8) ? win_base - 16'd1 : win_base + 16'(n);
        end else begin
          r.id = win_base + 16'($urandom_range(0, n - 1));
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
          r.value = '0;
        end else if (pick < 13) begin
          r.value = 32'h8000_0000;
        end else if (pick < 16) begin
          r.value = 32'h7FFF_FFFF;
        end else if (pick < 19) begin
          r.value = 32'hFFFF_FFFF;
        end else begin
          r.value = $urandom;
        end

        pick = $urandom_range(99);
        if (pick < 30) begin
          // Allocate, then claim the reported ID with a nonzero value.
          r.mode = isat_pkg::MODE_ALLOCATE;
          send_req(r, 1'b0, '{isat_pkg::ST_OK, '0, '0});
          sent++;
          if (lowest_free(slot_id)) begin
            r.mode  = isat_pkg::MODE_SET;
            r.id    = slot_id;
            r.value = $urandom;
            if (r.value == '0) begin
              r.value = 32'h1;
            end
            send_req(r, 1'b0, '{isat_pkg::ST_OK, '0, '0});
            sent++;
          end
        end else begin
          if (pick < 45) begin
            r.mode = isat_pkg::MODE_SET;
          end else if (pick < 60) begin
            r.mode = isat_pkg::MODE_GET;
          end else if (pick < 75) begin
            r.mode = isat_pkg::MODE_RELEASE;
          end else if (pick < 85) begin
            r.mode = isat_pkg::MODE_CHECK;
          end else begin
            // Noise: any mode code, any ID, any value.
            r.mode  = isat_pkg::MODE_W'($urandom_range(0, 7));
            r.id    = 16'($urandom);
            r.value = $urandom;
          end
          send_req(r, 1'b0, '{isat_pkg::ST_OK, '0, '0});
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/isat_pkg.sv
design/isat_ram.sv
design/isat_ctrl.sv
design/id_slot_allocator_table.sv
test/tb_id_slot_allocator_table.sv
